@@ hdl/rthc_pkg.sv @@
// shared types and constants for the rgb to hsl converter
package rthc_pkg;

   localparam int CHAN_W     = 8;
   localparam int PIXEL_W    = 24;
   localparam int HUE_W      = 9;
   localparam int PCT_W      = 7;
   localparam int SUM_W      = 9;
   localparam int DIV_W      = 16;
   localparam int DIV_STEPS  = 7;
   localparam int QUO_W      = DIV_STEPS;

   localparam int FULL_SCALE = 510;
   localparam int HALF_SCALE = 255;
   localparam int PCT_SCALE  = 100;
   localparam int DEG_SCALE  = 60;
   localparam int HUE_GREEN  = 120;
   localparam int HUE_BLUE   = 240;
   localparam int HUE_WRAP   = 360;

   // floor(sum * 100 / 510) == (sum * LIT_RECIP) >> LIT_SHIFT for sum <= 510
   localparam int LIT_RECIP  = 51410;
   localparam int LIT_SHIFT  = 18;
   localparam int LIT_PROD_W = 25;

   typedef enum logic [1:0] {
      SECTOR_GRAY,
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [DIV_W-1:0] dsh;
      logic [QUO_W-1:0] quo;
   } div_type;

   typedef struct packed {
      sector_type       sector;
      logic             neg;
      logic [PCT_W-1:0] lit;
      div_type          hue;
      div_type          sat;
   } pipe_type;

endpackage

@@ hdl/rgb_to_hsl_convert.sv @@
// top level of the pipelined rgb to hsl converter
// Converts one packed RGB pixel (red 23:16, green 15:8, blue 7:0) to integer
// hue in degrees (0..360), saturation and lightness in percent (0..100).
// The pipeline is nine register stages deep: operand setup, seven restoring
// division steps that produce the hue and saturation quotients side by side,
// and the result register. A new pixel is taken every cycle while rsp_ready
// keeps the pipeline moving. Each stage holds its item while the next one is
// full and stalled; the ready chain runs combinationally back through all
// stages, so a stall at rsp_ready reaches req_ready in the same cycle once
// every stage is full, and empty stages keep filling.
module rgb_to_hsl_convert (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [rthc_pkg::PIXEL_W-1:0] req_pixel_color,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rthc_pkg::HUE_W-1:0]   rsp_hue_degrees,
   output logic [rthc_pkg::PCT_W-1:0]   rsp_saturation_pct,
   output logic [rthc_pkg::PCT_W-1:0]   rsp_lightness_pct
);
   import rthc_pkg::*;

   pipe_type stage_data  [DIV_STEPS+1];
   logic     stage_valid [DIV_STEPS+1];
   logic     stage_ready [DIV_STEPS+1];

   rthc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .pixel_color (req_pixel_color),
      .out_valid   (stage_valid[0]),
      .out_ready   (stage_ready[0]),
      .out_data    (stage_data[0])
   );

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      rthc_div_stage u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_data   (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   rthc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (stage_valid[DIV_STEPS]),
      .in_ready       (stage_ready[DIV_STEPS]),
      .in_data        (stage_data[DIV_STEPS]),
      .out_valid      (rsp_valid),
      .out_ready      (rsp_ready),
      .hue_degrees    (rsp_hue_degrees),
      .saturation_pct (rsp_saturation_pct),
      .lightness_pct  (rsp_lightness_pct)
   );

endmodule

@@ hdl/rthc_front.sv @@
// first stage: max, min, sector, division operands and lightness
module rthc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [rthc_pkg::PIXEL_W-1:0] pixel_color,
   output logic                        out_valid,
   input  logic                        out_ready,
   output rthc_pkg::pipe_type          out_data
);
   import rthc_pkg::*;

   logic [CHAN_W-1:0]     red, green, blue, hi, lo, delta, mag, den;
   logic [SUM_W-1:0]      sum, light_den;
   logic [LIT_PROD_W-1:0] lit_prod;
   logic                  neg;
   sector_type            sector;
   pipe_type              data_in;
   pipe_type              data_ff;
   logic                  valid_ff;

   always_comb begin
      red   = pixel_color[23:16];
      green = pixel_color[15:8];
      blue  = pixel_color[7:0];
      hi    = red;
      lo    = red;
      if (green > hi) hi = green;
      if (blue > hi) hi = blue;
      if (green < lo) lo = green;
      if (blue < lo) lo = blue;
      delta = hi - lo;
      sum   = SUM_W'(hi) + SUM_W'(lo);

      if (delta == '0) begin
         sector = SECTOR_GRAY;
      end else if (hi == red) begin
         sector = SECTOR_RED;
      end else if (hi == green) begin
         sector = SECTOR_GREEN;
      end else begin
         sector = SECTOR_BLUE;
      end

      case (sector)
         SECTOR_RED: begin
            neg = green < blue;
            mag = neg ? blue - green : green - blue;
         end
         SECTOR_GREEN: begin
            neg = blue < red;
            mag = neg ? red - blue : blue - red;
         end
         SECTOR_BLUE: begin
            neg = red < green;
            mag = neg ? green - red : red - green;
         end
         default: begin
            neg = 1'b0;
            mag = '0;
         end
      endcase

      light_den = SUM_W'(FULL_SCALE) - sum;
      den       = (sum > SUM_W'(HALF_SCALE)) ? light_den[CHAN_W-1:0] : sum[CHAN_W-1:0];
      lit_prod  = LIT_PROD_W'(sum) * LIT_PROD_W'(LIT_RECIP);

      data_in.sector  = sector;
      data_in.neg     = neg;
      data_in.lit     = lit_prod[LIT_SHIFT +: PCT_W];
      data_in.hue.rem = DIV_W'(mag) * DIV_W'(DEG_SCALE);
      data_in.hue.dsh = DIV_W'(delta) << (DIV_STEPS - 1);
      data_in.hue.quo = '0;
      data_in.sat.rem = DIV_W'(delta) * DIV_W'(PCT_SCALE);
      data_in.sat.dsh = DIV_W'(den) << (DIV_STEPS - 1);
      data_in.sat.quo = '0;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ hdl/rthc_div_stage.sv @@
// one restoring division step for hue and saturation
module rthc_div_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rthc_pkg::pipe_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output rthc_pkg::pipe_type out_data
);
   import rthc_pkg::*;

   pipe_type data_in;
   pipe_type data_ff;
   logic     valid_ff;

   always_comb begin
      data_in = in_data;
      if (in_data.hue.rem >= in_data.hue.dsh) begin
         data_in.hue.rem = in_data.hue.rem - in_data.hue.dsh;
         data_in.hue.quo = {in_data.hue.quo[QUO_W-2:0], 1'b1};
      end else begin
         data_in.hue.quo = {in_data.hue.quo[QUO_W-2:0], 1'b0};
      end
      data_in.hue.dsh = in_data.hue.dsh >> 1;

      if (in_data.sat.rem >= in_data.sat.dsh) begin
         data_in.sat.rem = in_data.sat.rem - in_data.sat.dsh;
         data_in.sat.quo = {in_data.sat.quo[QUO_W-2:0], 1'b1};
      end else begin
         data_in.sat.quo = {in_data.sat.quo[QUO_W-2:0], 1'b0};
      end
      data_in.sat.dsh = in_data.sat.dsh >> 1;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ hdl/rthc_back.sv @@
// last stage: sector offset, gray override and result register
module rthc_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  rthc_pkg::pipe_type        in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [rthc_pkg::HUE_W-1:0] hue_degrees,
   output logic [rthc_pkg::PCT_W-1:0] saturation_pct,
   output logic [rthc_pkg::PCT_W-1:0] lightness_pct
);
   import rthc_pkg::*;

   logic [HUE_W-1:0] q9, base, hue_in, hue_ff;
   logic [PCT_W-1:0] sat_in, sat_ff, lit_ff;
   logic             valid_ff;

   always_comb begin
      q9     = HUE_W'(in_data.hue.quo);
      sat_in = in_data.sat.quo;
      case (in_data.sector)
         SECTOR_RED:   base = in_data.neg ? HUE_W'(HUE_WRAP) : '0;
         SECTOR_GREEN: base = HUE_W'(HUE_GREEN);
         SECTOR_BLUE:  base = HUE_W'(HUE_BLUE);
         default:      base = '0;
      endcase
      hue_in = in_data.neg ? base - q9 : base + q9;
      if (in_data.sector == SECTOR_GRAY) begin
         hue_in = '0;
         sat_in = '0;
      end
   end

   assign in_ready       = !valid_ff || out_ready;
   assign out_valid      = valid_ff;
   assign hue_degrees    = hue_ff;
   assign saturation_pct = sat_ff;
   assign lightness_pct  = lit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         hue_ff <= hue_in;
         sat_ff <= sat_in;
         lit_ff <= in_data.lit;
      end
   end

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the pipelined rgb to hsl converter
`timescale 1ns / 1ps

module testbench;
   import rthc_pkg::*;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic [HUE_W-1:0]   hue;
      logic [PCT_W-1:0]   sat;
      logic [PCT_W-1:0]   lit;
   } hsl_result_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               known;
      logic [HUE_W-1:0]   hue;
      logic [PCT_W-1:0]   sat;
      logic [PCT_W-1:0]   lit;
   } pixel_case_type;

   localparam int NUM_CASES   = 20;
   localparam int NUM_RANDOM  = 700;
   localparam int MAX_WAIT    = 14;
   localparam int LONG_STALL  = 120;
   localparam int DRAIN_WAIT  = 24;

   localparam pixel_case_type PIXEL_CASES [NUM_CASES] = '{
      '{24'h000000, 1'b1, 9'd0,   7'd0,   7'd0},
      '{24'hFFFFFF, 1'b1, 9'd0,   7'd0,   7'd100},
      '{24'hFF0000, 1'b1, 9'd0,   7'd100, 7'd50},
      '{24'h00FF00, 1'b1, 9'd120, 7'd100, 7'd50},
      '{24'h0000FF, 1'b1, 9'd240, 7'd100, 7'd50},
      '{24'hFF0001, 1'b1, 9'd360, 7'd100, 7'd50},
      '{24'h808080, 1'b1, 9'd0,   7'd0,   7'd50},
      '{24'h0F0F0F, 1'b1, 9'd0,   7'd0,   7'd5},
      '{24'hFFFF00, 1'b0, 9'd0,   7'd0,   7'd0},
      '{24'hFF00FF, 1'b0, 9'd0,   7'd0,   7'd0},
      '{24'h00FFFF, 1'b0, 9'd0,   7'd0,   7'd0},
      '{24'h010000, 1'b0, 9'd0,   7'd0,   7'd0},
      '{24'hFEFFFF, 1'b0, 9'd0,   7'd0,   7'd0},
      '{24'h7F8000, 1'b0, 9'd0,   7'd0,   7'd0},
      '{24'h3C1E5A, 1'b0, 9'd0,   7'd0,   7'd0},
      '{24'h1E5A3C, 1'b0, 9'd0,   7'd0,   7'd0},
      '{24'h5A1E3C, 1'b0, 9'd0,   7'd0,   7'd0},
      '{24'hAA5555, 1'b0, 9'd0,   7'd0,   7'd0},
      '{24'h55AAAA, 1'b0, 9'd0,   7'd0,   7'd0},
      '{24'hF0F0F1, 1'b0, 9'd0,   7'd0,   7'd0}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [PIXEL_W-1:0] req_pixel_color = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [HUE_W-1:0]   rsp_hue_degrees;
   logic [PCT_W-1:0]   rsp_saturation_pct;
   logic [PCT_W-1:0]   rsp_lightness_pct;

   hsl_result_type hsl_expected [$];
   int             mismatch_count = 0;
   bit             steady_flow = 1'b0;
   bit             long_stall_pending = 1'b0;

   rgb_to_hsl_convert i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pixel_color    (req_pixel_color),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_hue_degrees    (rsp_hue_degrees),
      .rsp_saturation_pct (rsp_saturation_pct),
      .rsp_lightness_pct  (rsp_lightness_pct)
   );

   always #1 clock = ~clock;

   function automatic hsl_result_type hsl_from_rgb(input logic [PIXEL_W-1:0] px);
      int r, g, b, hi, lo, delta, sum, hue, sat, lit;
      hsl_result_type res;
      r = int'(px[23:16]);
      g = int'(px[15:8]);
      b = int'(px[7:0]);
      hi = r;
      lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      delta = hi - lo;
      sum = hi + lo;
      lit = sum * PCT_SCALE / FULL_SCALE;
      hue = 0;
      sat = 0;
      if (delta != 0) begin
         if (sum > HALF_SCALE) sat = delta * PCT_SCALE / (FULL_SCALE - sum);
         else sat = delta * PCT_SCALE / sum;
         if (hi == r) begin
            hue = (g - b) * DEG_SCALE / delta;
            if (g < b) hue = hue + HUE_WRAP;
         end else if (hi == g) begin
            hue = (b - r) * DEG_SCALE / delta + HUE_GREEN;
         end else begin
            hue = (r - g) * DEG_SCALE / delta + HUE_BLUE;
         end
      end
      res.pixel = px;
      res.hue = hue[HUE_W-1:0];
      res.sat = sat[PCT_W-1:0];
      res.lit = lit[PCT_W-1:0];
      return res;
   endfunction

   function automatic logic [PIXEL_W-1:0] pick_pixel();
      int r, g, b, c, hi, arrangement;
      logic [PIXEL_W-1:0] px;
      px = PIXEL_W'($urandom);
      case ($urandom_range(0, 7))
         3: begin
            c = $urandom_range(0, 255);
            px = {c[7:0], c[7:0], c[7:0]};
         end
         4: begin
            hi = $urandom_range(1, 255);
            c = $urandom_range(0, hi);
            arrangement = $urandom_range(0, 2);
            if (arrangement == 0) px = {hi[7:0], hi[7:0], c[7:0]};
            else if (arrangement == 1) px = {hi[7:0], c[7:0], hi[7:0]};
            else px = {c[7:0], hi[7:0], hi[7:0]};
         end
         5: begin
            r = $urandom_range(0, 1) ? 255 : 0;
            g = $urandom_range(0, 1) ? 254 : 1;
            b = $urandom_range(0, 1) ? 255 : 0;
            case ($urandom_range(0, 2))
               0: px = {r[7:0], g[7:0], b[7:0]};
               1: px = {g[7:0], b[7:0], r[7:0]};
               default: px = {b[7:0], r[7:0], g[7:0]};
            endcase
         end
         6: begin
            r = $urandom_range(4, 255);
            g = $urandom_range(0, r - 4);
            b = g + $urandom_range(1, 3);
            px = {r[7:0], g[7:0], b[7:0]};
         end
         7: begin
            c = $urandom_range(0, 250);
            r = c + $urandom_range(0, 5);
            g = c + $urandom_range(0, 5);
            b = c + $urandom_range(0, 5);
            px = {r[7:0], g[7:0], b[7:0]};
         end
         default: ;
      endcase
      return px;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want,
                                  input logic [PIXEL_W-1:0] px);
      $display("%0t: pixel %06h %s got %0d expected %0d", $realtime, px, field, got, want);
      mismatch_count = mismatch_count + 1;
   endtask

   task automatic send_pixel(input logic [PIXEL_W-1:0] px, input hsl_result_type want);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_color <= px;
      do @(posedge clock); while (!req_ready);
      hsl_expected.push_back(want);
   endtask

   always @(posedge clock) begin
      hsl_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (hsl_expected.size() == 0) begin
            report_mismatch("unexpected transfer, hue", int'(rsp_hue_degrees), 0, 'x);
         end else begin
            want = hsl_expected.pop_front();
            if (rsp_hue_degrees !== want.hue)
               report_mismatch("hue", int'(rsp_hue_degrees), int'(want.hue), want.pixel);
            if (rsp_saturation_pct !== want.sat)
               report_mismatch("saturation", int'(rsp_saturation_pct), int'(want.sat),
                               want.pixel);
            if (rsp_lightness_pct !== want.lit)
               report_mismatch("lightness", int'(rsp_lightness_pct), int'(want.lit),
                               want.pixel);
         end
      end
   end

   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, MAX_WAIT);
         if (long_stall_pending) begin
            stall = LONG_STALL;
            long_stall_pending = 1'b0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      pixel_case_type row;
      hsl_result_type want;
      logic [PIXEL_W-1:0] px;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < NUM_CASES; i++) begin
         row = PIXEL_CASES[i];
         want = hsl_from_rgb(row.pixel);
         if (row.known) begin
            want.hue = row.hue;
            want.sat = row.sat;
            want.lit = row.lit;
         end
         send_pixel(row.pixel, want);
      end
      for (int i = 0; i < NUM_RANDOM; i++) begin
         // a burst with the receiver held off fills the pipeline
         steady_flow = ((i / 100) % 3 == 2) || (i >= 350 && i < 420);
         if (i == 350) long_stall_pending = 1'b1;
         px = pick_pixel();
         send_pixel(px, hsl_from_rgb(px));
      end
      req_valid <= 1'b0;
      steady_flow = 1'b0;
      while (hsl_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("%0t: timeout", $realtime);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
